// ===== design/colray_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colray_pkg
// shared constants, register indexes and types of the column raycaster
// ----------------------------------------------------------------------------
package colray_pkg;

  // geometry
  localparam int SCREEN_COLUMNS = 128;
  localparam int MAP_SIDE       = 16;
  localparam int MAX_DEPTH      = 16;
  localparam int FOV_ANGLE      = 8192;
  localparam int MARCH_STEP     = 410;
  localparam int QUARTER        = 16384;
  localparam int DEPTH_Q12      = MAX_DEPTH * 4096;

  // field widths
  localparam int COLUMN_W   = 7;
  localparam int DIST_W     = 17;
  localparam int CEIL_W     = 8;
  localparam int FLOOR_W    = 9;
  localparam int SHADE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // divider sizes
  localparam int NUM_W = 24;
  localparam int DEN_W = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_C    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_D    = 3'd7;

  // shade codes
  localparam logic [SHADE_W-1:0] SHADE_FULL   = 3'd0;
  localparam logic [SHADE_W-1:0] SHADE_DARK   = 3'd1;
  localparam logic [SHADE_W-1:0] SHADE_MEDIUM = 3'd2;
  localparam logic [SHADE_W-1:0] SHADE_LIGHT  = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_BLANK  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINE,
    ST_MARCH,
    ST_CORNER,
    ST_CEIL_PREP,
    ST_DIV,
    ST_DONE
  } colray_state_t;

endpackage
`default_nettype wire

// ===== design/colray_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colray_in_if
// column request channel, valid/ready
// ----------------------------------------------------------------------------
interface colray_in_if;
  import colray_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface
`default_nettype wire

// ===== design/colray_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colray_out_if
// column result channel, valid/ready
// ----------------------------------------------------------------------------
interface colray_out_if;
  import colray_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [DIST_W-1:0]         wall_distance;
  logic signed [CEIL_W-1:0]  ceiling_row;
  logic [FLOOR_W-1:0]        floor_row;
  logic [SHADE_W-1:0]        shade;
  logic                      corner_edge;
  logic                      hit_wall;

  modport source (output valid, output wall_distance, output ceiling_row,
                  output floor_row, output shade, output corner_edge,
                  output hit_wall, input ready);
  modport sink   (input valid, input wall_distance, input ceiling_row,
                  input floor_row, input shade, input corner_edge,
                  input hit_wall, output ready);
endinterface
`default_nettype wire

// ===== design/colray_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colray_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module colray_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [colray_pkg::NUM_W-1:0] num,
  input  wire logic [colray_pkg::DEN_W-1:0] den,
  output logic                              done,
  output logic [colray_pkg::NUM_W-1:0]      quot
);
  import colray_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift in next numerator bit, subtract when it fits
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

// ===== design/column_raycaster.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_raycaster
// casts one ray per screen column through a 16x16 wall map
// ----------------------------------------------------------------------------
// One column beat in gives one result beat out. The block handles one column
// at a time and drops ready from acceptance until its result is taken. A
// column passes through acceptance, sine/cosine and step setup on the shared
// multiplier, the march (one 0.1 cell step per cycle), a corner test when a
// wall is hit, numerator setup, the bit-serial ceiling divider and the result
// beat. Player position, heading, screen rows and wall bitmap are to be
// written through the cfg port only while no column is in flight; the user
// is bound to this, and the block itself does not enforce it.
module column_raycaster (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  colray_in_if.sink                              in_col,
  colray_out_if.source                           out_res,
  input  wire logic                              cfg_we,
  input  wire logic [colray_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [colray_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import colray_pkg::*;

  localparam logic [16:0] DEPTH = 17'(DEPTH_Q12);

  // configuration registers
  logic [15:0] player_x_r, player_y_r, heading_r;
  logic [7:0]  rows_r;
  logic [63:0] wall_a_r, wall_b_r, wall_c_r, wall_d_r;

  // control
  colray_state_t state_r, state_nxt;
  logic [4:0]    step_r, step_nxt;

  // datapath registers
  logic [15:0]        ang_r, ang_nxt;
  logic [12:0]        t2_r, t2_nxt;
  logic [12:0]        v_r, v_nxt;
  logic signed [13:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [22:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [25:0]        e2_r, e2_nxt;
  logic signed [31:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [16:0]        d_r, d_nxt;
  logic               hit_r, hit_nxt, graze_r, graze_nxt;
  logic [3:0]         cx_r, cx_nxt, cy_r, cy_nxt;
  logic [32:0]        sqx0_r, sqx0_nxt, sqx1_r, sqx1_nxt;
  logic [32:0]        sqy0_r, sqy0_nxt, sqy1_r, sqy1_nxt;
  logic [1:0]         n0_r, n0_nxt, n1_r, n1_nxt;
  logic signed [31:0] s_r, s_nxt;
  logic [59:0]        ssq_r, ssq_nxt, big_r, big_nxt;
  logic signed [60:0] k_r, k_nxt;
  logic               num_neg_r, num_neg_nxt;
  logic [NUM_W-1:0]   num_abs_r, num_abs_nxt;
  logic signed [7:0]  ceil_r, ceil_nxt;

  // shared multiplier
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // divider, numerator taken straight from the setup cycle
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quot;

  colray_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_abs_nxt),
    .den   ({d_r, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // quarter-wave offsets for sine and cosine
  logic [1:0]  q_s, q_c;
  logic [13:0] r_a;
  logic [14:0] off_s, off_c;
  logic [12:0] t_s, t_c, t_cur;
  logic        neg_cur;

  always_comb begin
    q_s     = ang_r[15:14];
    q_c     = q_s + 2'd1;
    r_a     = ang_r[13:0];
    off_s   = q_s[0] ? 15'(QUARTER) - {1'b0, r_a} : {1'b0, r_a};
    off_c   = q_c[0] ? 15'(QUARTER) - {1'b0, r_a} : {1'b0, r_a};
    t_s     = off_s[14:2];
    t_c     = off_c[14:2];
    t_cur   = step_r[2] ? t_c : t_s;
    neg_cur = step_r[2] ? q_c[1] : q_s[1];
  end

  // march step and map lookup
  logic signed [31:0] sx_n, sy_n;
  logic [16:0]        d_n;
  logic               oob, wall_here;
  logic [3:0]         cx_n, cy_n;
  logic [63:0]        wall_row4;

  always_comb begin
    sx_n = sx_r + 32'(dx_r);
    sy_n = sy_r + 32'(dy_r);
    d_n  = d_r + 17'(MARCH_STEP);
    oob  = sx_n[31] || sy_n[31] ||
           (sx_n[30:24] >= 7'(MAP_SIDE)) || (sy_n[30:24] >= 7'(MAP_SIDE));
    cx_n = sx_n[27:24];
    cy_n = sy_n[27:24];
    unique case (cy_n[3:2])
      2'd0: wall_row4 = wall_a_r;
      2'd1: wall_row4 = wall_b_r;
      2'd2: wall_row4 = wall_c_r;
      2'd3: wall_row4 = wall_d_r;
    endcase
    wall_here = wall_row4[{cy_n[1:0], cx_n}];
  end

  // corner vectors of the hit cell
  logic signed [17:0] vx0, vx1, vy0, vy1, vx_c, vy_c;
  logic [33:0]        d2 [4];
  logic [33:0]        d2_c;
  logic [1:0]         sel0, sel1, cur;
  logic               corner_b;
  logic [2:0]         rel;
  logic signed [61:0] one_minus_k;
  logic [75:0]        lim;
  logic               cond;

  always_comb begin
    vx0 = $signed({2'b0, cx_r, 12'b0}) - $signed({2'b0, player_x_r});
    vx1 = vx0 + 18'sd4096;
    vy0 = $signed({2'b0, cy_r, 12'b0}) - $signed({2'b0, player_y_r});
    vy1 = vy0 + 18'sd4096;
    d2[0] = {1'b0, sqx0_r} + {1'b0, sqy0_r};
    d2[1] = {1'b0, sqx0_r} + {1'b0, sqy1_r};
    d2[2] = {1'b0, sqx1_r} + {1'b0, sqy0_r};
    d2[3] = {1'b0, sqx1_r} + {1'b0, sqy1_r};
    // nearest corner, earliest wins ties
    sel0 = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (d2[i] < d2[sel0]) sel0 = 2'(i);
    end
    // second nearest
    sel1 = (sel0 == 2'd0) ? 2'd1 : 2'd0;
    for (int i = 0; i < 4; i++) begin
      if ((2'(i) != sel0) && (d2[i] < d2[sel1])) sel1 = 2'(i);
    end
    corner_b    = (step_r >= 5'd11);
    rel         = corner_b ? 3'(step_r - 5'd11) : 3'(step_r - 5'd5);
    cur         = corner_b ? n1_r : n0_r;
    vx_c        = cur[1] ? vx1 : vx0;
    vy_c        = cur[0] ? vy1 : vy0;
    d2_c        = d2[cur];
    // squared test s*s > big - big/10000, rewritten without the divide
    one_minus_k = 62'sd1 - 62'(k_r);
    lim         = 76'($unsigned(one_minus_k)) * 76'd10000;
    cond        = (s_r > 32'sd0) && ((k_r > 61'sd0) || (76'(big_r) >= lim));
  end

  // sequencer
  logic signed [17:0] d_minus;
  logic [12:0]        p_q;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    ang_nxt     = ang_r;
    t2_nxt      = t2_r;
    v_nxt       = v_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    e2_nxt      = e2_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    d_nxt       = d_r;
    hit_nxt     = hit_r;
    graze_nxt   = graze_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    sqx0_nxt    = sqx0_r;
    sqx1_nxt    = sqx1_r;
    sqy0_nxt    = sqy0_r;
    sqy1_nxt    = sqy1_r;
    n0_nxt      = n0_r;
    n1_nxt      = n1_r;
    s_nxt       = s_r;
    ssq_nxt     = ssq_r;
    big_nxt     = big_r;
    k_nxt       = k_r;
    num_neg_nxt = num_neg_r;
    num_abs_nxt = num_abs_r;
    ceil_nxt    = ceil_r;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    d_minus     = $signed({1'b0, d_r}) - 18'sd8192;
    p_q         = mul_p[24:12];

    unique case (state_r)
      ST_IDLE: begin
        if (in_col.valid) begin
          // ray angle: heading - fov/2 + column*fov/width
          ang_nxt   = heading_r - 16'(FOV_ANGLE / 2)
                      + 16'((20'(in_col.column) * 20'(FOV_ANGLE)) / SCREEN_COLUMNS);
          step_nxt  = '0;
          state_nxt = ST_SINE;
        end
      end

      ST_SINE: begin
        step_nxt = step_r + 5'd1;
        if (step_r < 5'd8) begin
          // polynomial quarter sine, pass 0 sine, pass 1 cosine
          unique case (step_r[1:0])
            2'd0: begin
              mul_a  = 35'(t_cur);
              mul_b  = 35'(t_cur);
              t2_nxt = p_q;
            end
            2'd1: begin
              mul_a = 35'(t2_r);
              mul_b = 35'd290;
              v_nxt = 13'd2628 - p_q;
            end
            2'd2: begin
              mul_a = 35'(v_r);
              mul_b = 35'(t2_r);
              v_nxt = 13'd6434 - p_q;
            end
            2'd3: begin
              mul_a = 35'(v_r);
              mul_b = 35'(t_cur);
              if (step_r[2]) begin
                ey_nxt = neg_cur ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
              end else begin
                ex_nxt = neg_cur ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
              end
            end
          endcase
        end else begin
          priority case (step_r)
            5'd8: begin
              mul_a  = 35'(ex_r);
              mul_b  = 35'(MARCH_STEP);
              dx_nxt = 23'(mul_p);
            end
            5'd9: begin
              mul_a  = 35'(ey_r);
              mul_b  = 35'(MARCH_STEP);
              dy_nxt = 23'(mul_p);
            end
            5'd10: begin
              mul_a  = 35'(ex_r);
              mul_b  = 35'(ex_r);
              e2_nxt = 26'(mul_p);
            end
            default: begin
              mul_a     = 35'(ey_r);
              mul_b     = 35'(ey_r);
              e2_nxt    = e2_r + 26'(mul_p);
              sx_nxt    = $signed({4'b0, player_x_r, 12'b0});
              sy_nxt    = $signed({4'b0, player_y_r, 12'b0});
              d_nxt     = '0;
              hit_nxt   = 1'b0;
              graze_nxt = 1'b0;
              state_nxt = ST_MARCH;
            end
          endcase
        end
      end

      ST_MARCH: begin
        sx_nxt = sx_n;
        sy_nxt = sy_n;
        priority if (oob) begin
          d_nxt     = DEPTH;
          state_nxt = ST_CEIL_PREP;
        end else if (wall_here) begin
          d_nxt     = (d_n > DEPTH) ? DEPTH : d_n;
          hit_nxt   = 1'b1;
          cx_nxt    = cx_n;
          cy_nxt    = cy_n;
          step_nxt  = '0;
          state_nxt = ST_CORNER;
        end else if (d_n >= DEPTH) begin
          d_nxt     = DEPTH;
          state_nxt = ST_CEIL_PREP;
        end else begin
          d_nxt = d_n;
        end
      end

      ST_CORNER: begin
        step_nxt = step_r + 5'd1;
        if (step_r < 5'd5) begin
          unique case (step_r[2:0])
            3'd0: begin
              mul_a    = 35'(vx0);
              mul_b    = 35'(vx0);
              sqx0_nxt = 33'(mul_p);
            end
            3'd1: begin
              mul_a    = 35'(vx1);
              mul_b    = 35'(vx1);
              sqx1_nxt = 33'(mul_p);
            end
            3'd2: begin
              mul_a    = 35'(vy0);
              mul_b    = 35'(vy0);
              sqy0_nxt = 33'(mul_p);
            end
            3'd3: begin
              mul_a    = 35'(vy1);
              mul_b    = 35'(vy1);
              sqy1_nxt = 33'(mul_p);
            end
            default: begin
              n0_nxt = sel0;
              n1_nxt = sel1;
            end
          endcase
        end else begin
          priority case (rel)
            3'd0: begin
              mul_a = 35'(ex_r);
              mul_b = 35'(vx_c);
              s_nxt = 32'(mul_p);
            end
            3'd1: begin
              mul_a = 35'(ey_r);
              mul_b = 35'(vy_c);
              s_nxt = s_r + 32'(mul_p);
            end
            3'd2: begin
              mul_a   = 35'(s_r);
              mul_b   = 35'(s_r);
              ssq_nxt = 60'(mul_p);
            end
            3'd3: begin
              mul_a   = $signed({1'b0, d2_c});
              mul_b   = 35'(e2_r);
              big_nxt = 60'(mul_p);
            end
            3'd4: begin
              k_nxt = $signed({1'b0, ssq_r}) - $signed({1'b0, big_r});
            end
            default: begin
              if (cond) graze_nxt = 1'b1;
              if (corner_b) state_nxt = ST_CEIL_PREP;
            end
          endcase
        end
      end

      ST_CEIL_PREP: begin
        // numerator h*(d - 8192), sign split off for the divider
        mul_a       = 35'(rows_r);
        mul_b       = 35'(d_minus);
        num_neg_nxt = mul_p[69];
        num_abs_nxt = mul_p[69] ? NUM_W'(-mul_p) : NUM_W'(mul_p);
        div_start   = 1'b1;
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          // negative quotients saturate at -1
          if (num_neg_r) begin
            ceil_nxt = (div_quot == '0) ? 8'sd0 : -8'sd1;
          end else begin
            ceil_nxt = $signed(div_quot[7:0]);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_res.ready) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r     <= ang_nxt;
    t2_r      <= t2_nxt;
    v_r       <= v_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    e2_r      <= e2_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    d_r       <= d_nxt;
    hit_r     <= hit_nxt;
    graze_r   <= graze_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    sqx0_r    <= sqx0_nxt;
    sqx1_r    <= sqx1_nxt;
    sqy0_r    <= sqy0_nxt;
    sqy1_r    <= sqy1_nxt;
    n0_r      <= n0_nxt;
    n1_r      <= n1_nxt;
    s_r       <= s_nxt;
    ssq_r     <= ssq_nxt;
    big_r     <= big_nxt;
    k_r       <= k_nxt;
    num_neg_r <= num_neg_nxt;
    num_abs_r <= num_abs_nxt;
    ceil_r    <= ceil_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= 16'd32768;
      player_y_r <= 16'd32768;
      heading_r  <= '0;
      rows_r     <= 8'd120;
      wall_a_r   <= '0;
      wall_b_r   <= '0;
      wall_c_r   <= '0;
      wall_d_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYER_X: player_x_r <= cfg_wdata[15:0];
        REG_PLAYER_Y: player_y_r <= cfg_wdata[15:0];
        REG_HEADING:  heading_r  <= cfg_wdata[15:0];
        REG_ROWS:     rows_r     <= cfg_wdata[7:0];
        REG_WALL_A:   wall_a_r   <= cfg_wdata;
        REG_WALL_B:   wall_b_r   <= cfg_wdata;
        REG_WALL_C:   wall_c_r   <= cfg_wdata;
        REG_WALL_D:   wall_d_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // result beat, held stable in the done state
  logic [SHADE_W-1:0] shade_c;
  logic [18:0]        d3;

  always_comb begin
    d3 = 19'(d_r) + 19'({d_r, 1'b0});
    priority if (graze_r)                          shade_c = SHADE_BLANK;
    else if (d_r <= 17'(DEPTH_Q12 / 4))            shade_c = SHADE_FULL;
    else if (d3 < 19'(DEPTH_Q12))                  shade_c = SHADE_DARK;
    else if ({d_r, 1'b0} < 18'(DEPTH_Q12))         shade_c = SHADE_MEDIUM;
    else if (d_r < DEPTH)                          shade_c = SHADE_LIGHT;
    else                                           shade_c = SHADE_BLANK;
  end

  assign in_col.ready          = (state_r == ST_IDLE);
  assign out_res.valid         = (state_r == ST_DONE);
  assign out_res.wall_distance = d_r;
  assign out_res.ceiling_row   = ceil_r;
  assign out_res.floor_row     = 9'(rows_r) - 9'(ceil_r);
  assign out_res.shade         = shade_c;
  assign out_res.corner_edge   = graze_r;
  assign out_res.hit_wall      = hit_r;

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_col.ready && out_res.valid))
    else $error("ready and result valid at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col.valid && in_col.ready) |=> !in_col.ready)
    else $error("still ready after accepting a column");

  a_miss_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.hit_wall) |-> (out_res.wall_distance == DEPTH))
    else $error("miss without full depth");

  a_edge_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.corner_edge && !out_res.hit_wall))
    else $error("corner edge without a wall hit");

endmodule
`default_nettype wire

// ===== dv/column_raycaster_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_raycaster_tb
// directed and random columns against an internal ray-march predictor, with
// random idling on both channels and several player/map settings
// ----------------------------------------------------------------------------
module column_raycaster_tb;
  import colray_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]        wall_dist;
    logic signed [CEIL_W-1:0] ceil_row;
    logic [FLOOR_W-1:0]       floor_row;
    logic [SHADE_W-1:0]       shade;
    logic                     edge_hit;
    logic                     wall_hit;
  } column_view_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  colray_in_if  in_if ();
  colray_out_if out_if ();

  column_raycaster dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_col    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the register file
  logic [15:0] pos_x, pos_y, heading;
  logic [7:0]  rows;
  logic [63:0] wall_map [4];

  column_view_t pending_views [$];
  int unsigned  mismatches;
  bit           idle_on;
  int           ready_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // quarter wave polynomial, offset 0..16384
  function automatic longint quarter_wave(int unsigned off);
    int unsigned t, t2, u, w, v;
    t  = off >> 2;
    t2 = (t * t) >> 12;
    u  = 2628 - ((290 * t2) >> 12);
    w  = (u * t2) >> 12;
    v  = 6434 - w;
    return longint'((v * t) >> 12);
  endfunction

  function automatic longint angle_sine(logic [15:0] a);
    longint m;
    m = a[14] ? quarter_wave(QUARTER - a[13:0]) : quarter_wave(a[13:0]);
    return a[15] ? -m : m;
  endfunction

  function automatic bit cell_is_wall(int unsigned cx, int unsigned cy);
    logic [63:0] r;
    r = wall_map[(cy >> 2) & 3];
    return r[((cy & 3) * 16 + (cx & 15)) & 63];
  endfunction

  // the two nearest corners of the hit cell, squared-terms alignment test
  function automatic bit near_corner_grazed(longint ex, longint ey,
                                            int unsigned cx, int unsigned cy);
    longint vx [4];
    longint vy [4];
    longint unsigned d2 [4];
    longint unsigned e2, big, ss;
    longint s;
    int n0, n1;
    bit hit_edge;
    n0 = 0;
    n1 = -1;
    hit_edge = 1'b0;
    e2 = longint'(ex * ex + ey * ey);
    for (int i = 0; i < 4; i++) begin
      vx[i] = longint'(cx + (i >> 1)) * 4096 - longint'(pos_x);
      vy[i] = longint'(cy + (i & 1)) * 4096 - longint'(pos_y);
      d2[i] = vx[i] * vx[i] + vy[i] * vy[i];
    end
    for (int i = 1; i < 4; i++)
      if (d2[i] < d2[n0]) n0 = i;
    for (int i = 0; i < 4; i++)
      if (i != n0 && (n1 < 0 || d2[i] < d2[n1])) n1 = i;
    for (int i = 0; i < 4; i++) begin
      if (i == n0 || i == n1) begin
        s = ex * vx[i] + ey * vy[i];
        if (s > 0) begin
          big = d2[i] * e2;
          ss  = longint'(s) * longint'(s);
          if (ss > big - big / 10000) hit_edge = 1'b1;
        end
      end
    end
    return hit_edge;
  endfunction

  function automatic column_view_t cast_column(logic [COLUMN_W-1:0] col);
    column_view_t v;
    logic [15:0] ang;
    longint ex, ey, d, h, num, ceil_v, sx, sy, depth;
    bit done, hit, grazed;
    logic [SHADE_W-1:0] sh;
    depth = DEPTH_Q12;
    ang = heading - 16'(FOV_ANGLE / 2) + 16'((int'(col) * FOV_ANGLE) / SCREEN_COLUMNS);
    ex = angle_sine(ang);
    ey = angle_sine(ang + 16'(QUARTER));
    d = 0;
    h = rows;
    done = 0;
    hit = 0;
    grazed = 0;
    while (!done && d < depth) begin
      d += MARCH_STEP;
      sx = longint'(pos_x) * 4096 + ex * d;
      sy = longint'(pos_y) * 4096 + ey * d;
      if (sx < 0 || sy < 0 || (sx >>> 24) >= MAP_SIDE || (sy >>> 24) >= MAP_SIDE) begin
        done = 1;
        d = depth;
      end else if (cell_is_wall(int'(sx >>> 24), int'(sy >>> 24))) begin
        done = 1;
        hit = 1;
        grazed = near_corner_grazed(ex, ey, int'(sx >>> 24), int'(sy >>> 24));
      end
    end
    if (d > depth) d = depth;
    // signed division truncates toward zero
    num = h * d - 8192 * h;
    ceil_v = num / (2 * d);
    if (ceil_v < -1) ceil_v = -1;
    if (4 * d <= depth)      sh = SHADE_FULL;
    else if (3 * d < depth)  sh = SHADE_DARK;
    else if (2 * d < depth)  sh = SHADE_MEDIUM;
    else if (d < depth)      sh = SHADE_LIGHT;
    else                     sh = SHADE_BLANK;
    if (grazed) sh = SHADE_BLANK;
    v.wall_dist = d[DIST_W-1:0];
    v.ceil_row  = ceil_v[CEIL_W-1:0];
    v.floor_row = 9'(h - ceil_v);
    v.shade     = sh;
    v.edge_hit  = grazed;
    v.wall_hit  = hit;
    return v;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      REG_PLAYER_X: pos_x   = val[15:0];
      REG_PLAYER_Y: pos_y   = val[15:0];
      REG_HEADING:  heading = val[15:0];
      REG_ROWS:     rows    = val[7:0];
      default:      wall_map[idx - REG_WALL_A] = val;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait until every column has been answered, plus a short settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_scene(logic [15:0] x, logic [15:0] y, logic [15:0] hd,
                           logic [7:0] r, logic [63:0] m0, logic [63:0] m1,
                           logic [63:0] m2, logic [63:0] m3);
    drain_results();
    write_reg(REG_PLAYER_X, 64'(x));
    write_reg(REG_PLAYER_Y, 64'(y));
    write_reg(REG_HEADING, 64'(hd));
    write_reg(REG_ROWS, 64'(r));
    write_reg(REG_WALL_A, m0);
    write_reg(REG_WALL_B, m1);
    write_reg(REG_WALL_C, m2);
    write_reg(REG_WALL_D, m3);
  endtask

  // one column beat; valid stays high across back-to-back beats
  task automatic send_column(logic [COLUMN_W-1:0] col);
    int gap;
    gap = idle_on ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.column <= col;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pending_views.insert(pending_views.size(), cast_column(col));
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // map word with each wall bit set at roughly 1 in 2^(k+1), empty for k above 5
  function automatic logic [63:0] sparse_word(int k);
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < k; i++) w &= {$urandom, $urandom};
    return (k > 5) ? 64'd0 : w;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold   <= ready_hold - 1;
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      // draw the stall ahead of the next result beat
      if (idle_on && $urandom_range(13, 0) != 0) begin
        ready_hold   <= $urandom_range(13, 1) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    column_view_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.wall_distance, out_if.ceiling_row, out_if.floor_row,
              out_if.shade, out_if.corner_edge, out_if.hit_wall};
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %p", got);
      end else begin
        want = pending_views.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("column result mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // screen edges, center, empty map (ray leaves the map)
  task automatic test_open_floor();
    set_scene(16'd32768, 16'd32768, 16'd0, 8'd120, 64'd0, 64'd0, 64'd0, 64'd0);
    send_column(7'd0);
    send_column(7'd127);
    send_column(7'd64);
    set_scene(16'd0, 16'd0, 16'd8192, 8'd255, 64'd0, 64'd0, 64'd0, 64'd0);
    send_column(7'd64);
    send_column(7'd0);
    set_scene(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd2, 64'd0, 64'd0, 64'd0, 64'd0);
    send_column(7'd127);
    send_column(7'd85);
    end_burst();
  endtask

  // solid map: wall at the first step, short distance, ceiling clamp
  task automatic test_solid_walls();
    set_scene(16'h1800, 16'h2800, 16'd16384, 8'd255, '1, '1, '1, '1);
    send_column(7'd0);
    send_column(7'd127);
    set_scene(16'h1800, 16'h2800, 16'd32768, 8'd0, '1, '1, '1, '1);
    send_column(7'd42);
    set_scene(16'h1800, 16'h2800, 16'd49152, 8'd1, '1, '1, '1, '1);
    send_column(7'd99);
    end_burst();
  endtask

  // walls all around the center cell, diagonal rays aimed at cell corners
  task automatic test_corner_graze();
    set_scene(16'h2800, 16'h2800, 16'd8192, 8'd120,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
    wall_map[0][2*16+2] = 1'b0;
    write_reg(REG_WALL_A, wall_map[0]);
    send_column(7'd64);
    set_scene(16'h2800, 16'h2800, 16'd8192, 8'd120, 64'h0000_0000_0008_0000, 0, 0, 0);
    send_column(7'd64);
    send_column(7'd63);
    send_column(7'd65);
    // hollow border: border hits from the map center along a diagonal heading
    set_scene(16'h8000, 16'h8000, 16'd40960, 8'd200, 64'h8001_8001_8001_FFFF,
              64'h8001_8001_8001_8001, 64'h8001_8001_8001_8001, 64'hFFFF_8001_8001_8001);
    send_column(7'd64);
    send_column(7'd0);
    send_column(7'd127);
    end_burst();
  endtask

  // random scenes with random columns
  task automatic test_random_scenes(int scenes, int per_scene);
    logic [15:0] x, y;
    int k;
    for (int s = 0; s < scenes; s++) begin
      k = $urandom_range(6, 1);
      x = (s % 4 == 0) ? 16'($urandom) : 16'($urandom_range(60000, 4000));
      y = (s % 4 == 0) ? 16'($urandom) : 16'($urandom_range(60000, 4000));
      set_scene(x, y, 16'($urandom), (s == 1) ? 8'd255 : 8'($urandom_range(255, 2)),
                sparse_word(k), sparse_word(k), sparse_word(k), sparse_word(k));
      idle_on = (s % 5 != 2);
      for (int i = 0; i < per_scene; i++) begin
        send_column(7'($urandom));
        // hold off once until the block has answered everything
        if (s == 3 && i == per_scene / 2) begin
          in_if.valid <= 1'b0;
          while (pending_views.size() != 0) @(posedge clk);
        end
      end
      end_burst();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.column = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    idle_on = 1'b1;
    pos_x = 16'd32768;
    pos_y = 16'd32768;
    heading = 16'd0;
    rows = 8'd120;
    foreach (wall_map[i]) wall_map[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: one column with the registers untouched
    send_column(7'd64);
    end_burst();
    test_open_floor();
    test_solid_walls();
    test_corner_graze();
    test_random_scenes(20, 32);

    drain_results();
    repeat (250) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
